[hdl/s2l_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_pkg: shared constants and tables
// Year table for 2000-2099 and helpers for the lunar month walk.
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int unsigned MaxYears = 100;
  localparam logic [4:0] LenShort = 5'h1d;
  localparam logic [4:0] LenLong  = 5'h1e;

  typedef logic [23:0] year_entry_t;

  function automatic year_entry_t year_rom(input logic [6:0] y);
    year_entry_t r;
    case (y)
      7'd0: r = 24'h0C9645; 7'd1: r = 24'h4D4AB8; 7'd2: r = 24'h0D4A4C; 7'd3: r = 24'h0DA541;
      7'd4: r = 24'h25AAB6; 7'd5: r = 24'h056A49; 7'd6: r = 24'h7AADBD; 7'd7: r = 24'h025D52;
      7'd8: r = 24'h092D47; 7'd9: r = 24'h5C95BA; 7'd10: r = 24'h0A954E; 7'd11: r = 24'h0B4A43;
      7'd12: r = 24'h4B5537; 7'd13: r = 24'h0AD54A; 7'd14: r = 24'h955ABF; 7'd15: r = 24'h04BA53;
      7'd16: r = 24'h0A5B48; 7'd17: r = 24'h652BBC; 7'd18: r = 24'h052B50; 7'd19: r = 24'h0A9345;
      7'd20: r = 24'h474AB9; 7'd21: r = 24'h06AA4C; 7'd22: r = 24'h0AD541; 7'd23: r = 24'h24DAB6;
      7'd24: r = 24'h04B64A; 7'd25: r = 24'h69573D; 7'd26: r = 24'h0A4E51; 7'd27: r = 24'h0D2646;
      7'd28: r = 24'h5E933A; 7'd29: r = 24'h0D534D; 7'd30: r = 24'h05AA43; 7'd31: r = 24'h36B537;
      7'd32: r = 24'h096D4B; 7'd33: r = 24'hB4AEBF; 7'd34: r = 24'h04AD53; 7'd35: r = 24'h0A4D48;
      7'd36: r = 24'h6D25BC; 7'd37: r = 24'h0D254F; 7'd38: r = 24'h0D5244; 7'd39: r = 24'h5DAA38;
      7'd40: r = 24'h0B5A4C; 7'd41: r = 24'h056D41; 7'd42: r = 24'h24ADB6; 7'd43: r = 24'h049B4A;
      7'd44: r = 24'h7A4BBE; 7'd45: r = 24'h0A4B51; 7'd46: r = 24'h0AA546; 7'd47: r = 24'h5B52BA;
      7'd48: r = 24'h06D24E; 7'd49: r = 24'h0ADA42; 7'd50: r = 24'h355B37; 7'd51: r = 24'h09374B;
      7'd52: r = 24'h8497C1; 7'd53: r = 24'h049753; 7'd54: r = 24'h064B48; 7'd55: r = 24'h66A53C;
      7'd56: r = 24'h0EA54F; 7'd57: r = 24'h06B244; 7'd58: r = 24'h4AB638; 7'd59: r = 24'h0AAE4C;
      7'd60: r = 24'h092E42; 7'd61: r = 24'h3C9735; 7'd62: r = 24'h0C9649; 7'd63: r = 24'h7D4ABD;
      7'd64: r = 24'h0D4A51; 7'd65: r = 24'h0DA545; 7'd66: r = 24'h55AABA; 7'd67: r = 24'h056A4E;
      7'd68: r = 24'h0A6D43; 7'd69: r = 24'h452EB7; 7'd70: r = 24'h052D4B; 7'd71: r = 24'h8A95BF;
      7'd72: r = 24'h0A9553; 7'd73: r = 24'h0B4A47; 7'd74: r = 24'h6B553B; 7'd75: r = 24'h0AD54F;
      7'd76: r = 24'h055A45; 7'd77: r = 24'h4A5D38; 7'd78: r = 24'h0A5B4C; 7'd79: r = 24'h052B42;
      7'd80: r = 24'h3A93B6; 7'd81: r = 24'h069349; 7'd82: r = 24'h7729BD; 7'd83: r = 24'h06AA51;
      7'd84: r = 24'h0AD546; 7'd85: r = 24'h54DABA; 7'd86: r = 24'h04B64E; 7'd87: r = 24'h0A5743;
      7'd88: r = 24'h452738; 7'd89: r = 24'h0D264A; 7'd90: r = 24'h8E933E; 7'd91: r = 24'h0D5252;
      7'd92: r = 24'h0DAA47; 7'd93: r = 24'h66B53B; 7'd94: r = 24'h056D4F; 7'd95: r = 24'h04AE45;
      7'd96: r = 24'h4A4EB9; 7'd97: r = 24'h0A4D4C; 7'd98: r = 24'h0D1541; 7'd99: r = 24'h2D92B5;
      default: r = 24'h000000;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1: r = 9'h000; 4'd2: r = 9'h01f; 4'd3: r = 9'h03b; 4'd4: r = 9'h05a;
      4'd5: r = 9'h078; 4'd6: r = 9'h097; 4'd7: r = 9'h0b5; 4'd8: r = 9'h0d4;
      4'd9: r = 9'h0f3; 4'd10: r = 9'h111; 4'd11: r = 9'h130; 4'd12: r = 9'h14e;
      default: r = 9'h000;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2: r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // month bits in order: bit 12 = month 1 ... bit 0 = month 13
  function automatic logic [4:0] lunar_len(input logic [12:0] bits, input logic [3:0] n);
    logic [4:0] r;
    r = LenShort;
    if (n >= 4'd1 && n <= 4'd13) begin
      if (bits[4'd13 - n]) r = LenLong;
    end
    return r;
  endfunction

  typedef struct packed {
    logic        valid;
    logic        bad;
    logic        fwd;
    logic [6:0]  ly;
    logic [3:0]  leap;
    logic [12:0] bits;
    logic [3:0]  n;
    logic [8:0]  r;
    logic        done;
  } walk_t;

endpackage

[hdl/solar_to_lunar_date_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_to_lunar_date_core: Gregorian 2000-2099 to Chinese lunar date
// Two setup stages, thirteen month steps, one output stage.
// Throughput one word per cycle; the pipeline advances whenever the output
// register is empty or being taken. Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
module solar_to_lunar_date_core #(
  parameter int unsigned TABLE_YEARS = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // solar_year[6:0], solar_month[10:7], solar_day[15:11]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // lunar_year[6:0], lunar_month[10:7], lunar_day[15:11]
  output logic        m_tuser    // out_of_range
);

  localparam int unsigned Steps = 13;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: validate, table lookup
  logic        v1, bad1, lp1;
  logic [6:0]  y1;
  logic [3:0]  m1;
  logic [4:0]  d1;
  logic [23:0] cur1, prv1;

  logic [6:0] iy;
  logic [3:0] im;
  logic [4:0] id;
  logic       ileap, ibad;
  assign iy = s_tdata[6:0];
  assign im = s_tdata[10:7];
  assign id = s_tdata[15:11];
  assign ileap = (iy[1:0] == 2'b00);
  always_comb begin
    ibad = ({25'd0, iy} >= TABLE_YEARS) || (iy > 7'd99) || (im < 4'd1) || (im > 4'd12)
        || (id < 5'd1);
    if (!ibad && id > s2l_pkg::month_days(im, ileap)) ibad = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      bad1 <= ibad;
      lp1  <= ileap;
      y1   <= iy;
      m1   <= im;
      d1   <= id;
      cur1 <= s2l_pkg::year_rom(iy);
      prv1 <= s2l_pkg::year_rom(iy - 7'd1);
    end
  end

  // stage 2: offsets, direction
  logic [8:0] fest, off, c2r;
  logic       fwd2;
  s2l_pkg::walk_t w0;
  s2l_pkg::walk_t w [Steps+1];

  always_comb begin
    fest = (cur1[6:5] == 2'd1) ? {4'd0, cur1[4:0]} : {4'd0, cur1[4:0]} + 9'h01f;
    off = s2l_pkg::days_before(m1) + {4'd0, d1};
    if (m1 > 4'd2 && lp1) off = off + 9'd1;
    fwd2 = off >= fest;
    c2r = fwd2 ? off - fest : fest - off;
  end

  always_ff @(posedge clk) begin
    if (rst) w0.valid <= 1'b0;
    else if (en) w0.valid <= v1;
    if (en) begin
      w0.fwd  <= fwd2;
      w0.r    <= c2r;
      w0.done <= 1'b0;
      if (fwd2) begin
        w0.bad  <= bad1;
        w0.ly   <= y1;
        w0.leap <= cur1[23:20];
        w0.bits <= {cur1[19:16], cur1[15:8], cur1[7]};
        w0.n    <= 4'd1;
      end else begin
        w0.bad  <= bad1 || (y1 == 7'd0);
        w0.ly   <= y1 - 7'd1;
        w0.leap <= prv1[23:20];
        w0.bits <= {prv1[19:16], prv1[15:8], prv1[7]};
        w0.n    <= (prv1[23:20] != 4'd0) ? 4'd13 : 4'd12;
      end
    end
  end

  assign w[0] = w0;

  for (genvar g = 0; g < Steps; g++) begin : g_walk
    s2l_walk u_walk (.clk(clk), .rst(rst), .en(en), .din(w[g]), .dout(w[g+1]));
  end

  // output stage
  s2l_pkg::walk_t f;
  logic [4:0] flen;
  logic [3:0] lm;
  logic [4:0] ld;
  assign f = w[Steps];
  always_comb begin
    flen = s2l_pkg::lunar_len(f.bits, f.n);
    lm = (f.leap != 4'd0 && f.n > f.leap) ? f.n - 4'd1 : f.n;
    if (f.fwd) ld = f.r[4:0] + 5'd1;
    else ld = ({4'd0, flen} >= f.r) ? flen - f.r[4:0] + 5'd1 : 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= f.valid;
    if (en) begin
      m_tuser <= f.bad;
      m_tdata <= f.bad ? 16'd0 : {ld, lm, f.ly};
    end
  end

endmodule

[hdl/s2l_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_walk: one lunar month step of the walk
// Registered stage that removes one month length from the remaining offset, or marks the walk done.
// ----------------------------------------------------------------------------
module s2l_walk (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  s2l_pkg::walk_t  din,
  output s2l_pkg::walk_t  dout
);

  s2l_pkg::walk_t nxt;
  logic [4:0] len;

  always_comb begin
    nxt = din;
    len = s2l_pkg::lunar_len(din.bits, din.n);
    if (din.fwd) begin
      if (!din.done && din.r >= {4'd0, len} && din.n < 4'd13) begin
        nxt.r = din.r - {4'd0, len};
        nxt.n = din.n + 4'd1;
      end else begin
        nxt.done = 1'b1;
      end
    end else begin
      if (!din.done && din.r > {4'd0, len} && din.n > 4'd1) begin
        nxt.r = din.r - {4'd0, len};
        nxt.n = din.n - 4'd1;
      end else begin
        nxt.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.bad  <= nxt.bad;
      dout.fwd  <= nxt.fwd;
      dout.ly   <= nxt.ly;
      dout.leap <= nxt.leap;
      dout.bits <= nxt.bits;
      dout.n    <= nxt.n;
      dout.r    <= nxt.r;
      dout.done <= nxt.done;
    end
  end

endmodule
